@@ src/lac_pkg.sv @@
package lac_pkg;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 12;
    localparam int OFF_W      = 13;
    localparam int HGT_W      = 12;
    localparam int LOG_W      = 13;
    localparam int TOL_W      = 10;
    localparam int CNT_W      = 4;
    localparam int SPD_W      = 12;
    localparam int TGT_W      = 15;
    localparam int MAG_W      = 11;
    localparam int LIMS_W     = 24;

    // register indexes on the configuration port
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_LOW_BAND   = 3'd0,
        REG_HIGH_BAND  = 3'd1,
        REG_TOL_LOW    = 3'd2,
        REG_TOL_MID    = 3'd3,
        REG_TOL_HIGH   = 3'd4,
        REG_CONFIRM    = 3'd5,
        REG_STEP       = 3'd6,
        REG_SPEED_LIM  = 3'd7
    } cfg_index_t;

    localparam logic [HGT_W-1:0] RST_LOW_BAND  = 12'd600;
    localparam logic [HGT_W-1:0] RST_HIGH_BAND = 12'd1000;
    localparam logic [TOL_W-1:0] RST_TOL_LOW   = 10'd60;
    localparam logic [TOL_W-1:0] RST_TOL_MID   = 10'd100;
    localparam logic [TOL_W-1:0] RST_TOL_HIGH  = 10'd200;
    localparam logic [CNT_W-1:0] RST_CONFIRM   = 4'd3;
    localparam logic [TOL_W-1:0] RST_STEP      = 10'd200;
    localparam logic [TOL_W-1:0] RST_SPEED_LIM = 10'd100;

    // (limit + 1) * 10000: first value of 3*h*|off| that saturates
    localparam logic [LIMS_W-1:0] RST_LIM_SCALED = 24'd1010000;
    localparam logic [13:0]       SCALE_DIV      = 14'd10000;

    // floor(y / 625) = (y * RECIP_625) >> 30 for y below 2^20
    localparam logic [20:0] RECIP_625 = 21'd1717987;
    // floor(x / 10) = (x * RECIP_10) >> 19 for x below 2^18
    localparam logic [15:0] RECIP_10  = 16'd52429;

    typedef struct packed {
        logic                    low;
        logic                    land;
        logic signed [TGT_W-1:0] tgt;
        logic [CNT_W-1:0]        count;
    } lac_ctrl_t;

endpackage

@@ src/lac_speed_path.sv @@
module lac_speed_path (
    input  logic                                 clk,
    input  logic                                 adv,
    input  logic [lac_pkg::HGT_W-1:0]            height,
    input  logic signed [lac_pkg::OFF_W-1:0]     offset,
    input  logic [lac_pkg::TOL_W-1:0]            limit,
    input  logic [lac_pkg::LIMS_W-1:0]           limit_scaled,
    output logic [lac_pkg::MAG_W-1:0]            mag,
    output logic [lac_pkg::MAG_W-1:0]            mag_low,
    output logic                                 neg
);

    logic [lac_pkg::OFF_W-1:0]  off_abs;
    logic [24:0]                prod_next;
    logic [24:0]                prod_reg;
    logic                       neg2_reg;
    logic [26:0]                x3;
    logic [40:0]                recip_prod;
    logic [lac_pkg::TOL_W-1:0]  base_next;
    logic [lac_pkg::TOL_W-1:0]  base_reg;
    logic                       neg3_reg;
    logic [13:0]                x11;
    logic [29:0]                w_prod;
    logic [lac_pkg::MAG_W-1:0]  w_next;
    logic [lac_pkg::MAG_W-1:0]  w_reg;
    logic                       neg4_reg;
    logic [13:0]                x12;
    logic [29:0]                u_prod;

    // magnitude path; truncation toward zero is applied to |value| and sign put back later
    assign off_abs   = offset[lac_pkg::OFF_W-1] ? lac_pkg::OFF_W'(-offset)
                                                 : lac_pkg::OFF_W'(offset);
    assign prod_next = 25'(height) * 25'(off_abs);

    assign x3         = {1'b0, prod_reg, 1'b0} + {2'b00, prod_reg};
    // divide by 10000 as a shift by 4 then a reciprocal multiply by 1/625
    assign recip_prod = 41'(x3[23:4]) * 41'(lac_pkg::RECIP_625);
    assign base_next  = (x3 >= 27'(limit_scaled)) ? limit : recip_prod[39:30];

    assign x11    = 14'(base_reg) * 14'd11;
    assign w_prod = 30'(x11) * 30'(lac_pkg::RECIP_10);
    assign w_next = w_prod[29:19];

    assign x12    = 14'(w_reg) * 14'd12;
    assign u_prod = 30'(x12) * 30'(lac_pkg::RECIP_10);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg <= prod_next;
            neg2_reg <= offset[lac_pkg::OFF_W-1];
            base_reg <= base_next;
            neg3_reg <= neg2_reg;
            w_reg    <= w_next;
            neg4_reg <= neg3_reg;
        end
    end

    assign mag     = w_reg;
    assign mag_low = u_prod[29:19];
    assign neg     = neg4_reg;

endmodule

@@ src/landing_approach_controller.sv @@
// Landing approach controller. Each transaction on the input channel carries the target offset,
// the measured height and the logged height of one control tick, and gives one result transaction.
// A new tick is taken every cycle unless the output is held; the velocity path is a pipeline
// (input registers, offset times height, scale by 3/10000 and clamp, scale by 11/10 and, in the
// low band, by 12/10 into the output register), while the band decision, height target and
// confirmation counter are settled in the first stage so consecutive ticks see the counter in
// order. When the output is held the whole pipeline holds. Configuration registers are written
// over their own channel, which is always ready; writes belong to times when no tick is in flight.
module landing_approach_controller (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [lac_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  logic [lac_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [lac_pkg::OFF_W-1:0]     offset_x_mm,
    input  logic signed [lac_pkg::OFF_W-1:0]     offset_y_mm,
    input  logic [lac_pkg::HGT_W-1:0]            height_mm,
    input  logic [lac_pkg::LOG_W-1:0]            log_height_mm,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [lac_pkg::SPD_W-1:0]     speed_fwd,
    output logic signed [lac_pkg::SPD_W-1:0]     speed_right,
    output logic signed [lac_pkg::TGT_W-1:0]     target_height_mm,
    output logic                                 land_now,
    output logic [lac_pkg::CNT_W-1:0]            confirm_level
);

    logic [lac_pkg::HGT_W-1:0]   low_band_reg;
    logic [lac_pkg::HGT_W-1:0]   high_band_reg;
    logic [lac_pkg::TOL_W-1:0]   tol_low_reg;
    logic [lac_pkg::TOL_W-1:0]   tol_mid_reg;
    logic [lac_pkg::TOL_W-1:0]   tol_high_reg;
    logic [lac_pkg::CNT_W-1:0]   confirm_reg;
    logic [lac_pkg::TOL_W-1:0]   step_reg;
    logic [lac_pkg::TOL_W-1:0]   limit_reg;
    logic [lac_pkg::LIMS_W-1:0]  lim_scaled_reg;
    logic [lac_pkg::LIMS_W-1:0]  lim_scaled_next;

    logic                        adv;
    logic                        v1_reg, v2_reg, v3_reg, v4_reg;
    logic                        out_valid_reg;
    logic [lac_pkg::CNT_W-1:0]   count_reg;

    logic signed [lac_pkg::OFF_W-1:0] ox_reg;
    logic signed [lac_pkg::OFF_W-1:0] oy_reg;
    logic [lac_pkg::HGT_W-1:0]   h_reg;
    logic [lac_pkg::LOG_W-1:0]   lh_reg;

    lac_pkg::lac_ctrl_t          ctrl_next;
    lac_pkg::lac_ctrl_t          ctrl2_reg, ctrl3_reg, ctrl4_reg;

    logic [lac_pkg::MAG_W-1:0]   mag_x, mag_x_low, mag_y, mag_y_low;
    logic                        neg_x, neg_y;

    logic signed [lac_pkg::SPD_W-1:0] spd_x_next, spd_y_next;
    logic signed [lac_pkg::SPD_W-1:0] spd_x_reg, spd_y_reg;
    logic signed [lac_pkg::TGT_W-1:0] tgt_reg;
    logic                        land_reg;
    logic [lac_pkg::CNT_W-1:0]   level_reg;

    assign cfg_ready       = 1'b1;
    assign lim_scaled_next = lac_pkg::LIMS_W'((lac_pkg::LIMS_W'(cfg_data[lac_pkg::TOL_W-1:0]) + 1'b1)
                             * lac_pkg::LIMS_W'(lac_pkg::SCALE_DIV));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_band_reg   <= lac_pkg::RST_LOW_BAND;
            high_band_reg  <= lac_pkg::RST_HIGH_BAND;
            tol_low_reg    <= lac_pkg::RST_TOL_LOW;
            tol_mid_reg    <= lac_pkg::RST_TOL_MID;
            tol_high_reg   <= lac_pkg::RST_TOL_HIGH;
            confirm_reg    <= lac_pkg::RST_CONFIRM;
            step_reg       <= lac_pkg::RST_STEP;
            limit_reg      <= lac_pkg::RST_SPEED_LIM;
            lim_scaled_reg <= lac_pkg::RST_LIM_SCALED;
        end
        else if (cfg_valid)
        begin
            unique case (lac_pkg::cfg_index_t'(cfg_addr))
                lac_pkg::REG_LOW_BAND:  low_band_reg  <= cfg_data;
                lac_pkg::REG_HIGH_BAND: high_band_reg <= cfg_data;
                lac_pkg::REG_TOL_LOW:   tol_low_reg   <= cfg_data[lac_pkg::TOL_W-1:0];
                lac_pkg::REG_TOL_MID:   tol_mid_reg   <= cfg_data[lac_pkg::TOL_W-1:0];
                lac_pkg::REG_TOL_HIGH:  tol_high_reg  <= cfg_data[lac_pkg::TOL_W-1:0];
                lac_pkg::REG_CONFIRM:   confirm_reg   <= cfg_data[lac_pkg::CNT_W-1:0];
                lac_pkg::REG_STEP:      step_reg      <= cfg_data[lac_pkg::TOL_W-1:0];
                lac_pkg::REG_SPEED_LIM:
                begin
                    limit_reg      <= cfg_data[lac_pkg::TOL_W-1:0];
                    lim_scaled_reg <= lim_scaled_next;
                end
                default: ;
            endcase
        end
    end

    // whole pipeline moves together whenever the output register can take a result
    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else if (adv)
        begin
            v1_reg        <= in_valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            out_valid_reg <= v4_reg;
            if (v1_reg)
                count_reg <= ctrl_next.count;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ox_reg    <= offset_x_mm;
            oy_reg    <= offset_y_mm;
            h_reg     <= height_mm;
            lh_reg    <= log_height_mm;
            ctrl2_reg <= ctrl_next;
            ctrl3_reg <= ctrl2_reg;
            ctrl4_reg <= ctrl3_reg;
            spd_x_reg <= spd_x_next;
            spd_y_reg <= spd_y_next;
            tgt_reg   <= ctrl4_reg.tgt;
            land_reg  <= ctrl4_reg.land;
            level_reg <= ctrl4_reg.count;
        end
    end

    // band decision and counter
    always_comb
    begin
        logic [lac_pkg::OFF_W-1:0]        ax;
        logic [lac_pkg::OFF_W-1:0]        ay;
        logic [lac_pkg::TOL_W-1:0]        tol;
        logic                             centred;
        logic [lac_pkg::CNT_W-1:0]        inc;
        logic signed [lac_pkg::TGT_W-1:0] lh_ext;
        logic signed [lac_pkg::TGT_W-1:0] step_ext;

        ax       = ox_reg[lac_pkg::OFF_W-1] ? lac_pkg::OFF_W'(-ox_reg) : lac_pkg::OFF_W'(ox_reg);
        ay       = oy_reg[lac_pkg::OFF_W-1] ? lac_pkg::OFF_W'(-oy_reg) : lac_pkg::OFF_W'(oy_reg);
        lh_ext   = lac_pkg::TGT_W'(lh_reg);
        step_ext = lac_pkg::TGT_W'(step_reg);
        inc      = count_reg + 1'b1;

        ctrl_next.low   = h_reg < low_band_reg;
        ctrl_next.land  = 1'b0;
        ctrl_next.tgt   = lh_ext;
        ctrl_next.count = '0;

        if (ctrl_next.low)
            tol = tol_low_reg;
        else if (h_reg < high_band_reg)
            tol = tol_mid_reg;
        else
            tol = tol_high_reg;

        centred = (ax < lac_pkg::OFF_W'(tol)) && (ay < lac_pkg::OFF_W'(tol));

        if (ctrl_next.low)
        begin
            if (centred)
            begin
                if (inc >= confirm_reg)
                    ctrl_next.land = 1'b1;
                else
                    ctrl_next.count = inc;
            end
            else
                ctrl_next.tgt = lac_pkg::TGT_W'(lh_ext + step_ext);
        end
        else if (centred)
            ctrl_next.tgt = lac_pkg::TGT_W'(lh_ext - step_ext);
    end

    lac_speed_path u_speed_x (
        .clk          (clk),
        .adv          (adv),
        .height       (h_reg),
        .offset       (ox_reg),
        .limit        (limit_reg),
        .limit_scaled (lim_scaled_reg),
        .mag          (mag_x),
        .mag_low      (mag_x_low),
        .neg          (neg_x)
    );

    lac_speed_path u_speed_y (
        .clk          (clk),
        .adv          (adv),
        .height       (h_reg),
        .offset       (oy_reg),
        .limit        (limit_reg),
        .limit_scaled (lim_scaled_reg),
        .mag          (mag_y),
        .mag_low      (mag_y_low),
        .neg          (neg_y)
    );

    always_comb
    begin
        logic [lac_pkg::MAG_W-1:0] mx;
        logic [lac_pkg::MAG_W-1:0] my;

        mx = ctrl4_reg.land ? '0 : (ctrl4_reg.low ? mag_x_low : mag_x);
        my = ctrl4_reg.land ? '0 : (ctrl4_reg.low ? mag_y_low : mag_y);
        spd_x_next = neg_x ? -$signed({1'b0, mx}) : $signed({1'b0, mx});
        spd_y_next = neg_y ? -$signed({1'b0, my}) : $signed({1'b0, my});
    end

    assign out_valid        = out_valid_reg;
    assign speed_fwd        = spd_x_reg;
    assign speed_right      = spd_y_reg;
    assign target_height_mm = tgt_reg;
    assign land_now         = land_reg;
    assign confirm_level    = level_reg;

    a_land_clears : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && land_reg |->
            level_reg == '0 && spd_x_reg == '0 && spd_y_reg == '0)
        else $error("land result with nonzero speed or counter");

    a_count_hold : assert property (@(posedge clk) disable iff (!rst_n)
        !(adv && v1_reg) |=> $stable(count_reg))
        else $error("counter moved without a tick leaving the first stage");

    a_count_target : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && level_reg != '0 |-> !land_reg && !tgt_reg[lac_pkg::TGT_W-1])
        else $error("counting tick with land or negative target");

endmodule

@@ tb/sv/tb_landing_approach_controller.sv @@
`timescale 1ns / 1ps

module tb_landing_approach_controller;

    typedef struct packed {
        logic signed [lac_pkg::OFF_W-1:0] ox;
        logic signed [lac_pkg::OFF_W-1:0] oy;
        logic [lac_pkg::HGT_W-1:0]        h;
        logic [lac_pkg::LOG_W-1:0]        lh;
    } tick_t;

    typedef struct packed {
        logic signed [lac_pkg::SPD_W-1:0] fwd;
        logic signed [lac_pkg::SPD_W-1:0] right;
        logic signed [lac_pkg::TGT_W-1:0] tgt;
        logic                             land;
        logic [lac_pkg::CNT_W-1:0]        level;
    } command_t;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    lac_pkg::cfg_index_t              cfg_addr = lac_pkg::REG_LOW_BAND;
    logic [lac_pkg::CFG_DATA_W-1:0]   cfg_data = '0;
    logic                             in_valid = 1'b0;
    logic                             in_ready;
    logic signed [lac_pkg::OFF_W-1:0] offset_x_mm = '0;
    logic signed [lac_pkg::OFF_W-1:0] offset_y_mm = '0;
    logic [lac_pkg::HGT_W-1:0]        height_mm = '0;
    logic [lac_pkg::LOG_W-1:0]        log_height_mm = '0;
    logic                             out_valid;
    logic                             out_ready = 1'b0;
    logic signed [lac_pkg::SPD_W-1:0] speed_fwd;
    logic signed [lac_pkg::SPD_W-1:0] speed_right;
    logic signed [lac_pkg::TGT_W-1:0] target_height_mm;
    logic                             land_now;
    logic [lac_pkg::CNT_W-1:0]        confirm_level;

    // shadow registers and centred counter
    logic [lac_pkg::HGT_W-1:0] low_band_q  = lac_pkg::RST_LOW_BAND;
    logic [lac_pkg::HGT_W-1:0] high_band_q = lac_pkg::RST_HIGH_BAND;
    logic [lac_pkg::TOL_W-1:0] tol_low_q   = lac_pkg::RST_TOL_LOW;
    logic [lac_pkg::TOL_W-1:0] tol_mid_q   = lac_pkg::RST_TOL_MID;
    logic [lac_pkg::TOL_W-1:0] tol_high_q  = lac_pkg::RST_TOL_HIGH;
    logic [lac_pkg::CNT_W-1:0] confirm_q   = lac_pkg::RST_CONFIRM;
    logic [lac_pkg::TOL_W-1:0] step_q      = lac_pkg::RST_STEP;
    logic [lac_pkg::TOL_W-1:0] speed_lim_q = lac_pkg::RST_SPEED_LIM;
    logic [lac_pkg::CNT_W-1:0] centred_q   = '0;

    tick_t    tick_queue[$];
    command_t command_queue[$];
    tick_t    issue;
    command_t oldest;
    logic     steady = 1'b0;
    int       mismatch_count = 0;

    landing_approach_controller dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_addr         (cfg_addr),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .offset_x_mm      (offset_x_mm),
        .offset_y_mm      (offset_y_mm),
        .height_mm        (height_mm),
        .log_height_mm    (log_height_mm),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .speed_fwd        (speed_fwd),
        .speed_right      (speed_right),
        .target_height_mm (target_height_mm),
        .land_now         (land_now),
        .confirm_level    (confirm_level)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint magnitude(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic int clip(int v, int lo, int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // clamped base velocity scaled by 11/10, truncating toward zero
    function automatic longint base_velocity(longint h, longint off);
        longint v;
        longint lim;
        v = (3 * h * off) / 10000;
        lim = longint'(speed_lim_q);
        if (v > lim)
            v = lim;
        if (v < -lim)
            v = -lim;
        return (v * 11) / 10;
    endfunction

    // commands for one tick; updates the centred counter
    function automatic command_t advance_tick(tick_t t);
        longint ox;
        longint oy;
        longint h;
        longint lh;
        longint vx;
        longint vy;
        longint tgt;
        longint tol;
        logic [lac_pkg::CNT_W-1:0] count_after;
        command_t c;
        ox = $signed(t.ox);
        oy = $signed(t.oy);
        h = longint'(t.h);
        lh = longint'(t.lh);
        vx = base_velocity(h, ox);
        vy = base_velocity(h, oy);
        tgt = lh;
        count_after = '0;
        c.land = 1'b0;
        if (h < longint'(low_band_q))
        begin
            tol = longint'(tol_low_q);
            vx = (vx * 12) / 10;
            vy = (vy * 12) / 10;
            if (magnitude(ox) < tol && magnitude(oy) < tol)
            begin
                count_after = centred_q + 1'b1;
                if (count_after >= confirm_q)
                begin
                    c.land = 1'b1;
                    count_after = '0;
                    vx = 0;
                    vy = 0;
                end
            end
            else
            begin
                tgt = lh + longint'(step_q);
            end
        end
        else
        begin
            tol = (h < longint'(high_band_q)) ? longint'(tol_mid_q) : longint'(tol_high_q);
            if (magnitude(ox) < tol && magnitude(oy) < tol)
                tgt = lh - longint'(step_q);
        end
        centred_q = count_after;
        c.fwd = vx[lac_pkg::SPD_W-1:0];
        c.right = vy[lac_pkg::SPD_W-1:0];
        c.tgt = tgt[lac_pkg::TGT_W-1:0];
        c.level = count_after;
        return c;
    endfunction

    task automatic report_mismatch(string what);
        $display("%0t: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic check_field(string name, logic signed [15:0] got, logic signed [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
    endtask

    // starts at a clock edge, returns at the edge where the write is taken
    task automatic write_reg(input lac_pkg::cfg_index_t idx,
                             input logic [lac_pkg::CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            lac_pkg::REG_LOW_BAND:  low_band_q = val;
            lac_pkg::REG_HIGH_BAND: high_band_q = val;
            lac_pkg::REG_TOL_LOW:   tol_low_q = val[lac_pkg::TOL_W-1:0];
            lac_pkg::REG_TOL_MID:   tol_mid_q = val[lac_pkg::TOL_W-1:0];
            lac_pkg::REG_TOL_HIGH:  tol_high_q = val[lac_pkg::TOL_W-1:0];
            lac_pkg::REG_CONFIRM:   confirm_q = val[lac_pkg::CNT_W-1:0];
            lac_pkg::REG_STEP:      step_q = val[lac_pkg::TOL_W-1:0];
            lac_pkg::REG_SPEED_LIM: speed_lim_q = val[lac_pkg::TOL_W-1:0];
            default: ;
        endcase
    endtask

    task automatic load_settings(int lo, int hi, int tl, int tm, int th, int cc, int st, int sp);
        write_reg(lac_pkg::REG_LOW_BAND, lo[lac_pkg::CFG_DATA_W-1:0]);
        write_reg(lac_pkg::REG_HIGH_BAND, hi[lac_pkg::CFG_DATA_W-1:0]);
        write_reg(lac_pkg::REG_TOL_LOW, tl[lac_pkg::CFG_DATA_W-1:0]);
        write_reg(lac_pkg::REG_TOL_MID, tm[lac_pkg::CFG_DATA_W-1:0]);
        write_reg(lac_pkg::REG_TOL_HIGH, th[lac_pkg::CFG_DATA_W-1:0]);
        write_reg(lac_pkg::REG_CONFIRM, cc[lac_pkg::CFG_DATA_W-1:0]);
        write_reg(lac_pkg::REG_STEP, st[lac_pkg::CFG_DATA_W-1:0]);
        write_reg(lac_pkg::REG_SPEED_LIM, sp[lac_pkg::CFG_DATA_W-1:0]);
        cfg_valid <= 1'b0;
    endtask

    task automatic add_tick(int ox, int oy, int h, int lh);
        tick_t t;
        t.ox = ox[lac_pkg::OFF_W-1:0];
        t.oy = oy[lac_pkg::OFF_W-1:0];
        t.h = h[lac_pkg::HGT_W-1:0];
        t.lh = lh[lac_pkg::LOG_W-1:0];
        tick_queue.insert(tick_queue.size(), t);
    endtask

    function automatic int any_offset();
        return int'($urandom_range(8191)) - 4096;
    endfunction

    function automatic int centred_offset(int tol);
        int m;
        if (tol <= 0)
            return any_offset();
        m = int'($urandom_range(tol - 1));
        return ($urandom_range(1) == 0) ? -m : m;
    endfunction

    // just inside, on, or just outside the tolerance
    function automatic int near_offset(int tol);
        int m;
        m = clip(tol + int'($urandom_range(2)) - 1, 0, 4095);
        return ($urandom_range(1) == 0) ? -m : m;
    endfunction

    function automatic int low_height();
        if (low_band_q == 0)
            return int'($urandom_range(4095));
        return int'($urandom_range(int'(low_band_q) - 1));
    endfunction

    task automatic add_random_ticks(int n);
        int left;
        int run;
        int k;
        int tol;
        int h;
        int a;
        int b;
        left = n;
        while (left > 0)
        begin
            k = int'($urandom_range(99));
            if (k < 45)
            begin
                // centred run in the low band, sometimes cut short
                run = int'($urandom_range(1, int'(confirm_q) + 2));
                for (int i = 0; i < run; i++)
                    add_tick(centred_offset(tol_low_q), centred_offset(tol_low_q), low_height(),
                             int'($urandom_range(8191)));
                left -= run;
                if ($urandom_range(2) == 0)
                begin
                    add_tick(near_offset(tol_low_q), centred_offset(tol_low_q), low_height(),
                             int'($urandom_range(8191)));
                    left--;
                end
            end
            else if (k < 75)
            begin
                // heights around the band edges, offsets around a tolerance
                h = ($urandom_range(1) == 0) ? int'(low_band_q) : int'(high_band_q);
                h = clip(h + int'($urandom_range(4)) - 2, 0, 4095);
                case ($urandom_range(2))
                    0:       tol = tol_low_q;
                    1:       tol = tol_mid_q;
                    default: tol = tol_high_q;
                endcase
                a = near_offset(tol);
                b = ($urandom_range(1) == 0) ? near_offset(tol) : centred_offset(tol);
                if ($urandom_range(1) == 0)
                    add_tick(a, b, h, int'($urandom_range(8191)));
                else
                    add_tick(b, a, h, int'($urandom_range(8191)));
                left--;
            end
            else
            begin
                add_tick(any_offset(), any_offset(), int'($urandom_range(4095)),
                         int'($urandom_range(8191)));
                left--;
            end
        end
    endtask

    task automatic wait_drained(int settle);
        while (tick_queue.size() != 0 || in_valid || command_queue.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                command_queue.insert(command_queue.size(),
                                     advance_tick(tick_t'({offset_x_mm, offset_y_mm,
                                                           height_mm, log_height_mm})));
            if (!in_valid || in_ready)
            begin
                if (tick_queue.size() != 0 && (steady || $urandom_range(99) >= 9))
                begin
                    issue = tick_queue.pop_front();
                    offset_x_mm <= issue.ox;
                    offset_y_mm <= issue.oy;
                    height_mm <= issue.h;
                    log_height_mm <= issue.lh;
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (command_queue.size() == 0)
                begin
                    report_mismatch("result transaction with no tick outstanding");
                end
                else
                begin
                    oldest = command_queue.pop_front();
                    check_field("speed_fwd", 16'(speed_fwd), 16'(oldest.fwd));
                    check_field("speed_right", 16'(speed_right), 16'(oldest.right));
                    check_field("target_height_mm", 16'(target_height_mm), 16'(oldest.tgt));
                    check_field("land_now", 16'(land_now), 16'(oldest.land));
                    check_field("confirm_level", 16'(confirm_level), 16'(oldest.level));
                end
            end
            out_ready <= steady || ($urandom_range(99) >= 9);
        end
    end

    initial
    begin
        int lo;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: low 600, high 1000, tolerances 60/100/200, confirm 3
        add_tick(-4096, 4095, 4095, 8191);
        add_tick(4095, -4096, 0, 0);
        add_tick(0, 0, 100, 50);
        add_tick(0, 0, 100, 50);
        add_tick(0, 0, 100, 50);
        add_tick(59, -59, 599, 8191);
        add_tick(60, 0, 599, 8191);
        add_tick(-59, 59, 1, 10);
        add_tick(10, 10, 2, 20);
        add_tick(0, -60, 3, 30);
        add_tick(99, -99, 600, 0);
        add_tick(100, 0, 600, 100);
        add_tick(-199, 199, 1000, 5000);
        add_tick(0, -200, 1000, 5000);
        add_tick(150, 0, 999, 300);
        add_tick(-7, 7, 1000, 0);
        add_tick(-1, -1, 4095, 8191);
        add_tick(4095, 4095, 1, 1);
        add_tick(-4096, -4096, 599, 0);
        add_random_ticks(125);
        wait_drained(10);

        for (int phase = 1; phase < 10; phase++)
        begin
            case (phase)
                1: load_settings(4095, 4095, 1023, 1023, 1023, 15, 1023, 1023);
                2: load_settings(0, 0, 0, 0, 0, 1, 0, 0);
                // zero confirm count lands on the first centred tick; bands swapped
                3: load_settings(2000, 800, 300, 500, 150, 0, 500, 700);
                default:
                begin
                    lo = int'($urandom_range(100, 2500));
                    load_settings(lo,
                                  ($urandom_range(3) == 0) ? int'($urandom_range(4095))
                                                           : clip(lo + int'($urandom_range(2000)),
                                                                  0, 4095),
                                  int'($urandom_range(1, 300)), int'($urandom_range(1023)),
                                  int'($urandom_range(1023)), int'($urandom_range(1, 15)),
                                  int'($urandom_range(1023)), int'($urandom_range(1023)));
                end
            endcase
            steady <= (phase == 6);
            if (phase == 5)
            begin
                // sender holds off until every result is back
                add_random_ticks(70);
                wait_drained(0);
                add_random_ticks(75);
            end
            else
            begin
                add_random_ticks(145);
            end
            wait_drained(10);
        end

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

@@ sim.f @@
src/lac_pkg.sv
src/lac_speed_path.sv
src/landing_approach_controller.sv
tb/sv/tb_landing_approach_controller.sv
